// ===== sv/erlm_pkg.sv =====
// Shared constants, codes and controller/datapath link types for the
// expert routing locality monitor. No dependencies.
package erlm_pkg;

    localparam int LAYERS         = 64;
    localparam int LAYER_W        = 6;
    localparam int MAX_PER_RECORD = 16;
    localparam int PCNT_W         = 5;
    localparam int PIDX_W         = 4;
    localparam int HIST_DEPTH     = 8;
    localparam int SLOT_W         = 3;
    localparam int FILL_W         = 4;
    localparam int RING_W         = SLOT_W + FILL_W;
    localparam int EXPERT_SLOTS   = 256;
    localparam int EXPERT_W       = 8;
    localparam int NUM_EXP_W      = 9;
    localparam int SET_W          = 256;
    localparam int POP_W          = 9;
    localparam int STEP_W         = 24;
    localparam int BOUND_W        = 25;
    localparam int VALUE_W        = 32;
    localparam int CNT_ADDR_W     = LAYER_W + EXPERT_W;
    localparam int CNT_DEPTH      = LAYERS * EXPERT_SLOTS;
    localparam int HIST_ADDR_W    = LAYER_W + SLOT_W;
    localparam int HIST_ROWS      = LAYERS * HIST_DEPTH;
    localparam int STEP_CTR_W     = 5;
    localparam int PADDR_W        = 3;
    localparam int PDATA_W        = 32;
    localparam int NUM_EXP_RESET  = 256;

    typedef enum logic [1:0] {
        OP_SELECT         = 2'd0,
        OP_READ_COUNT     = 2'd1,
        OP_READ_MALFORMED = 2'd2,
        OP_READ_BOUND     = 2'd3
    } opcode_t;

    // register word index, taken from paddr[2]
    localparam logic REG_EXPERT_LIMIT = 1'b0;

    typedef struct packed {
        logic                    accept;
        logic                    clear_we;
        logic [CNT_ADDR_W-1:0]   clear_addr;
        logic                    proc;
        logic [STEP_CTR_W-1:0]   step;
        logic                    rd_count;
        logic                    finish;
    } erlm_cmd_t;

    typedef struct packed {
        logic [1:0]              in_op;
        logic                    in_last;
        logic [1:0]              op;
        logic                    pend_bad;
        logic [PCNT_W-1:0]       pend_count;
        logic                    slot_free;
    } erlm_stat_t;

endpackage

// ===== sv/erlm_in_if.sv =====
// Input channel: valid/ready plus one routing item or read request.
// Depends on erlm_pkg.
interface erlm_in_if import erlm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [1:0]           opcode;
    logic [LAYER_W-1:0]   layer;
    logic [EXPERT_W-1:0]  expert;
    logic [STEP_W-1:0]    step;
    logic                 last;

    modport source (output valid, opcode, layer, expert, step, last, input ready);
    modport sink   (input valid, opcode, layer, expert, step, last, output ready);
endinterface

// ===== sv/erlm_out_if.sv =====
// Output channel: valid/ready plus one record report or read reply.
// Depends on erlm_pkg.
interface erlm_out_if import erlm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [1:0]           kind;
    logic [LAYER_W-1:0]   report_layer;
    logic                 record_ok;
    logic [4:0]           record_size;
    logic [4:0]           overlap;
    logic                 overlap_valid;
    logic [4:0]           union_one;
    logic [5:0]           union_two;
    logic [6:0]           union_four;
    logic [7:0]           union_eight;
    logic [3:0]           windows_valid;
    logic [VALUE_W-1:0]   read_value;

    modport source (output valid, kind, report_layer, record_ok, record_size, overlap,
                    overlap_valid, union_one, union_two, union_four, union_eight,
                    windows_valid, read_value, input ready);
    modport sink   (input valid, kind, report_layer, record_ok, record_size, overlap,
                    overlap_valid, union_one, union_two, union_four, union_eight,
                    windows_valid, read_value, output ready);
endinterface

// ===== sv/erlm_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module erlm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== sv/erlm_ctrl.sv =====
// Sequencer: clearing sweep, item intake, record walk and result hand-off.
// Depends on erlm_pkg.
module erlm_ctrl import erlm_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  erlm_stat_t stat,
    output erlm_cmd_t  cmd
);
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECIDE,
        S_PROC,
        S_FINISH
    } state_t;

    state_t                state_reg;
    logic [CNT_ADDR_W-1:0] clr_reg;
    logic [STEP_CTR_W-1:0] step_reg;
    logic [STEP_CTR_W-1:0] end_step;

    // walk runs until both the count updates and the seven history reads are done
    assign end_step = (stat.pend_count > STEP_CTR_W'(HIST_DEPTH - 1))
                      ? stat.pend_count : STEP_CTR_W'(HIST_DEPTH - 1);

    assign in_ready       = (state_reg == S_IDLE);
    assign cmd.accept     = in_valid && in_ready;
    assign cmd.clear_we   = (state_reg == S_CLEAR);
    assign cmd.clear_addr = clr_reg;
    assign cmd.proc       = (state_reg == S_PROC);
    assign cmd.step       = step_reg;
    assign cmd.rd_count   = (state_reg == S_DECIDE) && (stat.op == OP_READ_COUNT);
    assign cmd.finish     = (state_reg == S_FINISH) && stat.slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (&clr_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (cmd.accept && !(stat.in_op == OP_SELECT && !stat.in_last))
                    begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    step_reg <= '0;
                    if (stat.op == OP_SELECT && !stat.pend_bad)
                    begin
                        state_reg <= S_PROC;
                    end
                    else
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                S_PROC:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == end_step)
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    if (stat.slot_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

// ===== sv/erlm_dp.sv =====
// Datapath: pending record, per-layer rings, count and history memories,
// window unions and the output register. Depends on erlm_pkg, erlm_ram.
module erlm_dp import erlm_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  erlm_cmd_t             cmd,
    output erlm_stat_t            stat,
    input  logic [NUM_EXP_W-1:0]  expert_limit,
    input  logic [1:0]            in_opcode,
    input  logic [LAYER_W-1:0]    in_layer,
    input  logic [EXPERT_W-1:0]   in_expert,
    input  logic [STEP_W-1:0]     in_step,
    input  logic                  in_last,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [1:0]            out_kind,
    output logic [LAYER_W-1:0]    out_layer,
    output logic                  out_record_ok,
    output logic [4:0]            out_record_size,
    output logic [4:0]            out_overlap,
    output logic                  out_overlap_valid,
    output logic [4:0]            out_union_one,
    output logic [5:0]            out_union_two,
    output logic [6:0]            out_union_four,
    output logic [7:0]            out_union_eight,
    output logic [3:0]            out_windows_valid,
    output logic [VALUE_W-1:0]    out_read_value
);
    function automatic logic [POP_W-1:0] pop256(input logic [SET_W-1:0] v);
        logic [POP_W-1:0] n;
        n = '0;
        for (int k = 0; k < SET_W; k++)
        begin
            n = n + POP_W'(v[k]);
        end
        return n;
    endfunction

    logic [1:0]             op_reg;
    logic [LAYER_W-1:0]     layer_reg;
    logic [EXPERT_W-1:0]    ex_reg;
    logic [STEP_W-1:0]      step_reg;
    logic [SET_W-1:0]       pend_set_reg;
    logic [PCNT_W-1:0]      pend_count_reg;
    logic                   pend_bad_reg;
    logic [EXPERT_W-1:0]    pend_exp_reg [MAX_PER_RECORD];
    logic [VALUE_W-1:0]     malformed_reg;
    logic [BOUND_W-1:0]     bound_reg;
    logic [SET_W-1:0]       union_reg;
    logic [POP_W-1:0]       overlap_reg;
    logic [POP_W-1:0]       u2_reg;
    logic [POP_W-1:0]       u4_reg;
    logic [POP_W-1:0]       u8_reg;
    logic                   out_valid_reg;

    logic [SLOT_W-1:0]      head;
    logic [FILL_W-1:0]      fill_old;
    logic [FILL_W-1:0]      fill_new;
    logic [PIDX_W-1:0]      rd_idx;
    logic [PIDX_W-1:0]      wr_idx;
    logic [SET_W-1:0]       union_new;
    logic [BOUND_W-1:0]     step_plus;
    logic                   rec_good;
    logic [VALUE_W-1:0]     read_sel;

    logic                   cnt_we;
    logic [CNT_ADDR_W-1:0]  cnt_waddr;
    logic [VALUE_W-1:0]     cnt_wdata;
    logic                   cnt_re;
    logic [CNT_ADDR_W-1:0]  cnt_raddr;
    logic [VALUE_W-1:0]     cnt_rdata;
    logic                   hist_we;
    logic                   hist_re;
    logic [HIST_ADDR_W-1:0] hist_waddr;
    logic [HIST_ADDR_W-1:0] hist_raddr;
    logic [SET_W-1:0]       hist_rdata;
    logic                   step_in_hist;
    logic                   ring_we;
    logic [LAYER_W-1:0]     ring_waddr;
    logic [RING_W-1:0]      ring_wdata;
    logic [RING_W-1:0]      ring_rdata;

    // ring head and fill of the item's layer, read at every intake
    assign {head, fill_old} = ring_rdata;
    assign fill_new = (fill_old < FILL_W'(HIST_DEPTH)) ? fill_old + 1'b1 : fill_old;
    assign rd_idx   = cmd.step[PIDX_W-1:0];
    assign wr_idx   = rd_idx - 1'b1;
    assign step_plus = {1'b0, step_reg} + 1'b1;
    assign rec_good = (op_reg == OP_SELECT) && !pend_bad_reg;

    // count walk: read expert i while writing back expert i-1 (experts are distinct)
    assign cnt_re    = cmd.rd_count || (cmd.proc && (cmd.step < pend_count_reg));
    assign cnt_raddr = cmd.rd_count ? {layer_reg, ex_reg} : {layer_reg, pend_exp_reg[rd_idx]};
    assign cnt_we    = cmd.clear_we ||
                       (cmd.proc && (cmd.step != '0) && (cmd.step <= pend_count_reg));
    assign cnt_waddr = cmd.clear_we ? cmd.clear_addr : {layer_reg, pend_exp_reg[wr_idx]};
    assign cnt_wdata = cmd.clear_we ? '0 : ((&cnt_rdata) ? cnt_rdata : cnt_rdata + 1'b1);

    // history: new set goes to head, slots head-1 .. head-7 come back at steps 1..7
    assign hist_we      = cmd.proc && (cmd.step == '0);
    assign hist_waddr   = {layer_reg, head};
    assign hist_re      = cmd.proc && (cmd.step < STEP_CTR_W'(HIST_DEPTH - 1));
    assign hist_raddr   = {layer_reg, head - cmd.step[SLOT_W-1:0] - 1'b1};
    assign step_in_hist = cmd.proc && (cmd.step != '0) &&
                          (cmd.step <= STEP_CTR_W'(HIST_DEPTH - 1));
    assign union_new    = union_reg | hist_rdata;

    // ring state: zeroed by the clearing sweep, advanced when a good record finishes
    assign ring_we    = cmd.clear_we || (cmd.finish && rec_good);
    assign ring_waddr = cmd.clear_we ? cmd.clear_addr[LAYER_W-1:0] : layer_reg;
    assign ring_wdata = cmd.clear_we ? '0 : {head + 1'b1, fill_new};

    erlm_ram #(.WIDTH(VALUE_W), .DEPTH(CNT_DEPTH)) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    erlm_ram #(.WIDTH(SET_W), .DEPTH(HIST_ROWS)) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (pend_set_reg),
        .re    (hist_re),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    erlm_ram #(.WIDTH(RING_W), .DEPTH(LAYERS)) u_ring_ram (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (ring_wdata),
        .re    (cmd.accept),
        .raddr (in_layer),
        .rdata (ring_rdata)
    );

    assign stat.in_op      = in_opcode;
    assign stat.in_last    = in_last;
    assign stat.op         = op_reg;
    assign stat.pend_bad   = pend_bad_reg;
    assign stat.pend_count = pend_count_reg;
    assign stat.slot_free  = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;

    always_comb
    begin
        case (op_reg)
            OP_READ_COUNT:     read_sel = cnt_rdata;
            OP_READ_MALFORMED: read_sel = malformed_reg;
            OP_READ_BOUND:     read_sel = VALUE_W'(bound_reg);
            default:           read_sel = '0;
        endcase
    end

    // item capture, union walk: no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg    <= in_opcode;
            layer_reg <= in_layer;
            ex_reg    <= in_expert;
            step_reg  <= in_step;
            if (in_opcode == OP_SELECT && pend_count_reg < PCNT_W'(MAX_PER_RECORD))
            begin
                pend_exp_reg[pend_count_reg[PIDX_W-1:0]] <= in_expert;
            end
        end
        if (hist_we)
        begin
            union_reg <= pend_set_reg;
        end
        if (step_in_hist)
        begin
            union_reg <= union_new;
            case (cmd.step[SLOT_W-1:0])
                3'd1:
                begin
                    u2_reg      <= pop256(union_new);
                    overlap_reg <= pop256(pend_set_reg & hist_rdata);
                end
                3'd3:    u4_reg <= pop256(union_new);
                3'd7:    u8_reg <= pop256(union_new);
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_set_reg   <= '0;
            pend_count_reg <= '0;
            pend_bad_reg   <= 1'b0;
            malformed_reg  <= '0;
            bound_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // layer is always below LAYERS at this width, so no layer check
            if (cmd.accept && in_opcode == OP_SELECT)
            begin
                if (pend_count_reg >= PCNT_W'(MAX_PER_RECORD))
                begin
                    pend_bad_reg <= 1'b1;
                end
                else
                begin
                    if (({1'b0, in_expert} >= expert_limit) || pend_set_reg[in_expert])
                    begin
                        pend_bad_reg <= 1'b1;
                    end
                    else
                    begin
                        pend_set_reg[in_expert] <= 1'b1;
                    end
                    pend_count_reg <= pend_count_reg + 1'b1;
                end
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
                if (op_reg == OP_SELECT)
                begin
                    if (pend_bad_reg)
                    begin
                        if (!(&malformed_reg))
                        begin
                            malformed_reg <= malformed_reg + 1'b1;
                        end
                    end
                    else if (step_plus > bound_reg)
                    begin
                        bound_reg <= step_plus;
                    end
                    pend_set_reg   <= '0;
                    pend_count_reg <= '0;
                    pend_bad_reg   <= 1'b0;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // record fields are zero for reads and malformed records
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_kind          <= op_reg;
            out_layer         <= layer_reg;
            out_record_ok     <= rec_good;
            out_record_size   <= rec_good ? pend_count_reg : 5'd0;
            out_union_one     <= rec_good ? pend_count_reg : 5'd0;
            out_overlap_valid <= rec_good && (fill_old != '0);
            out_overlap       <= (rec_good && fill_old != '0) ? overlap_reg[4:0] : 5'd0;
            out_union_two     <= (rec_good && fill_new >= 4'd2) ? u2_reg[5:0] : 6'd0;
            out_union_four    <= (rec_good && fill_new >= 4'd4) ? u4_reg[6:0] : 7'd0;
            out_union_eight   <= (rec_good && fill_new >= 4'd8) ? u8_reg[7:0] : 8'd0;
            out_windows_valid <= rec_good ? {fill_new >= 4'd8, fill_new >= 4'd4,
                                             fill_new >= 4'd2, 1'b1} : 4'd0;
            out_read_value    <= read_sel;
        end
    end
endmodule

// ===== sv/expert_routing_locality_monitor.sv =====
// Expert routing locality monitor, top level. Depends on erlm_pkg, erlm_in_if,
// erlm_out_if, erlm_ctrl, erlm_dp.
// Sequence: a non-final selection item is only captured, no transfer; a read or a
//   malformed record passes decide and finish; a good record also runs the walk
//   (count updates, seven history reads). Input stays ready after a non-final item;
//   otherwise it is held off until finish, and longer while the output stalls.
// Reset: count memory and ring state swept to zero over every address, input held off.
module expert_routing_locality_monitor import erlm_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    erlm_in_if.sink              req,
    erlm_out_if.source           rsp,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);
    erlm_cmd_t            cmd;
    erlm_stat_t           stat;
    logic [NUM_EXP_W-1:0] expert_limit_reg;

    // APB register file: one word, the expert limit, at byte address 0
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_EXPERT_LIMIT) ? PDATA_W'(expert_limit_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expert_limit_reg <= NUM_EXP_W'(NUM_EXP_RESET);
        end
        else if (psel && penable && pwrite && pready && paddr[2] == REG_EXPERT_LIMIT)
        begin
            expert_limit_reg <= pwdata[NUM_EXP_W-1:0];
        end
    end

    // sequencer
    erlm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // storage and arithmetic; result register parts the two channels
    erlm_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .expert_limit      (expert_limit_reg),
        .in_opcode         (req.opcode),
        .in_layer          (req.layer),
        .in_expert         (req.expert),
        .in_step           (req.step),
        .in_last           (req.last),
        .out_ready         (rsp.ready),
        .out_valid         (rsp.valid),
        .out_kind          (rsp.kind),
        .out_layer         (rsp.report_layer),
        .out_record_ok     (rsp.record_ok),
        .out_record_size   (rsp.record_size),
        .out_overlap       (rsp.overlap),
        .out_overlap_valid (rsp.overlap_valid),
        .out_union_one     (rsp.union_one),
        .out_union_two     (rsp.union_two),
        .out_union_four    (rsp.union_four),
        .out_union_eight   (rsp.union_eight),
        .out_windows_valid (rsp.windows_valid),
        .out_read_value    (rsp.read_value)
    );

    // no intake during the clearing sweep
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_we |-> !req.ready)
        else $error("input ready during clearing sweep");

    // no intake while a record walk is running
    a_no_accept_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.proc |-> !req.ready)
        else $error("input ready during record walk");

    // read replies never carry a record verdict
    a_reply_not_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.kind != OP_SELECT) |-> !rsp.record_ok)
        else $error("read reply flagged as accepted record");

    // an accepted record always fills the one-set window
    a_window_one: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.record_ok) |-> rsp.windows_valid[0])
        else $error("accepted record without one-set window");
endmodule
